[hw/rtl/bidx_pkg.sv]
// Shared types and constants for the broadcast index generator.
package bidx_pkg;

   localparam int RANK = 4;
   localparam int AXIS_W = (RANK > 1) ? $clog2(RANK) : 1;
   localparam int SHAPE_W = 64;
   localparam int INDEX_W = 32;
   localparam int SIZE_W = 8;
   localparam int CSR_INDEX_W = 2;

   localparam logic [SHAPE_W-1:0] SHAPE_RESET = 64'h0101_0101_0101_0101;

   localparam logic [CSR_INDEX_W-1:0] CSR_SHAPE_A = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHAPE_B = 2'd1;

   typedef struct packed {
      logic busy;
      logic mismatch;
      logic [RANK-1:0][SIZE_W-1:0] size_out;
      logic [RANK-1:0][INDEX_W-1:0] carry_a;
      logic [RANK-1:0][INDEX_W-1:0] carry_b;
      logic [RANK-1:0][INDEX_W-1:0] carry_out;
   } bidx_tab_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index_a;
      logic [INDEX_W-1:0] index_b;
      logic [INDEX_W-1:0] index_out;
      logic last;
      logic shape_error;
   } bidx_res_type;

endpackage

[hw/rtl/bidx_derive.sv]
// Shape registers and the per-axis stride and carry derivation, one axis per cycle.
module bidx_derive (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [bidx_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bidx_pkg::SHAPE_W-1:0] csr_data,
   output bidx_pkg::bidx_tab_type tab
);

   logic [bidx_pkg::SHAPE_W-1:0] shape_a_ff, shape_b_ff;
   logic busy_ff, busy_in;
   logic mismatch_ff, mismatch_in;
   logic [bidx_pkg::AXIS_W-1:0] axis_ff, axis_in;
   logic [bidx_pkg::INDEX_W-1:0] pa_ff, pb_ff, po_ff, pa_in, pb_in, po_in;
   logic [bidx_pkg::INDEX_W-1:0] suma_ff, sumb_ff, sumo_ff, suma_in, sumb_in, sumo_in;
   logic [bidx_pkg::RANK-1:0][bidx_pkg::SIZE_W-1:0] size_ff;
   logic [bidx_pkg::RANK-1:0][bidx_pkg::INDEX_W-1:0] carry_a_ff, carry_b_ff, carry_o_ff;

   logic [bidx_pkg::SIZE_W-1:0] byte_a, byte_b, sa, sb, so, so_m1;
   logic [bidx_pkg::INDEX_W-1:0] st_a, st_b;
   logic [bidx_pkg::INDEX_W-1:0] carry_a_in, carry_b_in, carry_o_in;
   logic [bidx_pkg::INDEX_W+bidx_pkg::SIZE_W-1:0] pa_prod, pb_prod, po_prod;
   logic [bidx_pkg::INDEX_W+bidx_pkg::SIZE_W-1:0] ba_prod, bb_prod, bo_prod;
   logic cfg_hit;

   assign cfg_hit = csr_write &&
                    (csr_index == bidx_pkg::CSR_SHAPE_A || csr_index == bidx_pkg::CSR_SHAPE_B);

   always_comb begin
      byte_a = shape_a_ff[bidx_pkg::SIZE_W*axis_ff +: bidx_pkg::SIZE_W];
      byte_b = shape_b_ff[bidx_pkg::SIZE_W*axis_ff +: bidx_pkg::SIZE_W];
      sa = (byte_a == '0) ? 8'd1 : byte_a;
      sb = (byte_b == '0) ? 8'd1 : byte_b;
      so = (sa > sb) ? sa : sb;
      so_m1 = so - 8'd1;
      st_a = (sa == 8'd1) ? '0 : pa_ff;
      st_b = (sb == 8'd1) ? '0 : pb_ff;
      pa_prod = {8'b0, pa_ff} * {32'b0, sa};
      pb_prod = {8'b0, pb_ff} * {32'b0, sb};
      po_prod = {8'b0, po_ff} * {32'b0, so};
      ba_prod = {8'b0, st_a} * {32'b0, so_m1};
      bb_prod = {8'b0, st_b} * {32'b0, so_m1};
      bo_prod = {8'b0, po_ff} * {32'b0, so_m1};
      carry_a_in = st_a - suma_ff;
      carry_b_in = st_b - sumb_ff;
      carry_o_in = po_ff - sumo_ff;

      busy_in = busy_ff;
      axis_in = axis_ff;
      mismatch_in = mismatch_ff;
      pa_in = pa_ff;
      pb_in = pb_ff;
      po_in = po_ff;
      suma_in = suma_ff;
      sumb_in = sumb_ff;
      sumo_in = sumo_ff;
      if (cfg_hit) begin
         busy_in = 1'b1;
         axis_in = '0;
         mismatch_in = 1'b0;
         pa_in = 32'd1;
         pb_in = 32'd1;
         po_in = 32'd1;
         suma_in = '0;
         sumb_in = '0;
         sumo_in = '0;
      end else if (busy_ff) begin
         if (sa != sb && sa != 8'd1 && sb != 8'd1) begin
            mismatch_in = 1'b1;
         end
         pa_in = pa_prod[bidx_pkg::INDEX_W-1:0];
         pb_in = pb_prod[bidx_pkg::INDEX_W-1:0];
         po_in = po_prod[bidx_pkg::INDEX_W-1:0];
         suma_in = suma_ff + ba_prod[bidx_pkg::INDEX_W-1:0];
         sumb_in = sumb_ff + bb_prod[bidx_pkg::INDEX_W-1:0];
         sumo_in = sumo_ff + bo_prod[bidx_pkg::INDEX_W-1:0];
         if (axis_ff == bidx_pkg::AXIS_W'(bidx_pkg::RANK - 1)) begin
            busy_in = 1'b0;
         end else begin
            axis_in = axis_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_a_ff <= bidx_pkg::SHAPE_RESET;
         shape_b_ff <= bidx_pkg::SHAPE_RESET;
         busy_ff <= 1'b1;
         axis_ff <= '0;
         mismatch_ff <= 1'b0;
         pa_ff <= 32'd1;
         pb_ff <= 32'd1;
         po_ff <= 32'd1;
         suma_ff <= '0;
         sumb_ff <= '0;
         sumo_ff <= '0;
      end else begin
         if (csr_write && csr_index == bidx_pkg::CSR_SHAPE_A) begin
            shape_a_ff <= csr_data;
         end
         if (csr_write && csr_index == bidx_pkg::CSR_SHAPE_B) begin
            shape_b_ff <= csr_data;
         end
         busy_ff <= busy_in;
         axis_ff <= axis_in;
         mismatch_ff <= mismatch_in;
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         po_ff <= po_in;
         suma_ff <= suma_in;
         sumb_ff <= sumb_in;
         sumo_ff <= sumo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && !cfg_hit) begin
         size_ff[axis_ff] <= so;
         carry_a_ff[axis_ff] <= carry_a_in;
         carry_b_ff[axis_ff] <= carry_b_in;
         carry_o_ff[axis_ff] <= carry_o_in;
      end
   end

   assign tab.busy = busy_ff;
   assign tab.mismatch = mismatch_ff;
   assign tab.size_out = size_ff;
   assign tab.carry_a = carry_a_ff;
   assign tab.carry_b = carry_b_ff;
   assign tab.carry_out = carry_o_ff;

endmodule

[hw/rtl/bidx_walk.sv]
// Walk position and running offsets, advanced by one element per accepted beat.
module bidx_walk (
   input  logic clock,
   input  logic reset,
   input  bidx_pkg::bidx_tab_type tab,
   input  logic step,
   input  logic restart,
   output bidx_pkg::bidx_res_type res
);

   logic [bidx_pkg::RANK-1:0][bidx_pkg::SIZE_W-1:0] count_ff, count_in, cur;
   logic [bidx_pkg::INDEX_W-1:0] off_a_ff, off_b_ff, off_o_ff;
   logic [bidx_pkg::INDEX_W-1:0] off_a_in, off_b_in, off_o_in;
   logic [bidx_pkg::INDEX_W-1:0] cur_a, cur_b, cur_o, add_a, add_b, add_o;
   logic [bidx_pkg::RANK-1:0] at_end;
   logic is_last, found;

   always_comb begin
      cur = restart ? '0 : count_ff;
      cur_a = restart ? '0 : off_a_ff;
      cur_b = restart ? '0 : off_b_ff;
      cur_o = restart ? '0 : off_o_ff;
      found = 1'b0;
      add_a = '0;
      add_b = '0;
      add_o = '0;
      count_in = cur;
      for (int k = 0; k < bidx_pkg::RANK; k++) begin
         at_end[k] = ({1'b0, cur[k]} + 9'd1) == {1'b0, tab.size_out[k]};
         if (!found) begin
            if (!at_end[k]) begin
               count_in[k] = cur[k] + 8'd1;
               add_a = tab.carry_a[k];
               add_b = tab.carry_b[k];
               add_o = tab.carry_out[k];
               found = 1'b1;
            end else begin
               count_in[k] = '0;
            end
         end
      end
      is_last = &at_end;
      off_a_in = is_last ? '0 : cur_a + add_a;
      off_b_in = is_last ? '0 : cur_b + add_b;
      off_o_in = is_last ? '0 : cur_o + add_o;

      if (tab.mismatch) begin
         res.index_a = '0;
         res.index_b = '0;
         res.index_out = '0;
         res.last = 1'b1;
         res.shape_error = 1'b1;
      end else begin
         res.index_a = cur_a;
         res.index_b = cur_b;
         res.index_out = cur_o;
         res.last = is_last;
         res.shape_error = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || tab.busy) begin
         count_ff <= '0;
         off_a_ff <= '0;
         off_b_ff <= '0;
         off_o_ff <= '0;
      end else if (step && !tab.mismatch) begin
         count_ff <= count_in;
         off_a_ff <= off_a_in;
         off_b_ff <= off_b_in;
         off_o_ff <= off_o_in;
      end
   end

endmodule

[hw/rtl/broadcast_index_generator.sv]
// Top level of the broadcast index generator: handshake, result register and checks.
// Latency: a result beat is valid in the cycle after its request beat is accepted.
// Throughput: one beat per cycle unless req_stall is high; each step is a single add
// of a precomputed carry. Strides are derived one axis per cycle, so after reset
// and after every shape write the request side is stalled until all axes are derived.
// Reset is synchronous and active high; it restores all-ones shapes and walk zero.
module broadcast_index_generator (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_restart,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [bidx_pkg::INDEX_W-1:0] rsp_index_a,
   output logic [bidx_pkg::INDEX_W-1:0] rsp_index_b,
   output logic [bidx_pkg::INDEX_W-1:0] rsp_index_out,
   output logic rsp_last,
   output logic rsp_shape_error,
   input  logic csr_write,
   input  logic [bidx_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bidx_pkg::SHAPE_W-1:0] csr_data
);

   bidx_pkg::bidx_tab_type tab;
   bidx_pkg::bidx_res_type res, res_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_stall = tab.busy || (rsp_valid_ff && rsp_stall);
   assign accept = req_valid && !req_stall;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   bidx_derive u_derive (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .tab(tab)
   );

   bidx_walk u_walk (
      .clock(clock),
      .reset(reset),
      .tab(tab),
      .step(accept),
      .restart(req_restart),
      .res(res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_index_a = res_ff.index_a;
   assign rsp_index_b = res_ff.index_b;
   assign rsp_index_out = res_ff.index_out;
   assign rsp_last = res_ff.last;
   assign rsp_shape_error = res_ff.shape_error;

   // A shape write starts a derivation, which holds off new requests.
   a_write_stalls: assert property (@(posedge clock) disable iff (reset)
      (csr_write && (csr_index == bidx_pkg::CSR_SHAPE_A || csr_index == bidx_pkg::CSR_SHAPE_B))
      |=> req_stall)
      else $error("request side not stalled after a shape write");

   // An accepted beat under incompatible shapes yields a flagged final result.
   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      (accept && tab.mismatch) |=> (rsp_valid && rsp_shape_error && rsp_last))
      else $error("mismatch beat not flagged");

   // A restart beat always reports element zero.
   a_restart_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && req_restart) |=>
      (rsp_index_a == '0 && rsp_index_b == '0 && rsp_index_out == '0))
      else $error("restart beat did not report element zero");

endmodule

[bench/broadcast_index_generator_tb.sv]
// Self-checking testbench for the broadcast index generator: directed and random shapes.
`timescale 1ns / 1ps

class index_scoreboard;
   logic [bidx_pkg::SHAPE_W-1:0] shape_a;
   logic [bidx_pkg::SHAPE_W-1:0] shape_b;
   int unsigned dim [bidx_pkg::RANK];
   int unsigned position [bidx_pkg::RANK];
   logic [bidx_pkg::INDEX_W-1:0] pitch_a [bidx_pkg::RANK];
   logic [bidx_pkg::INDEX_W-1:0] pitch_b [bidx_pkg::RANK];
   logic [bidx_pkg::INDEX_W-1:0] pitch_out [bidx_pkg::RANK];
   bit incompatible;
   bidx_pkg::bidx_res_type expected_q [$];
   int unsigned mismatches;
   int unsigned beats_checked;
   int unsigned walks_done;
   int unsigned error_beats;

   function new();
      shape_a = bidx_pkg::SHAPE_RESET;
      shape_b = bidx_pkg::SHAPE_RESET;
      mismatches = 0;
      beats_checked = 0;
      walks_done = 0;
      error_beats = 0;
      derive_strides();
   endfunction

   function int unsigned axis_size(logic [bidx_pkg::SHAPE_W-1:0] shape, int k);
      int unsigned s;
      s = 32'(shape[8*k +: 8]);
      return (s == 0) ? 1 : s;
   endfunction

   function void derive_strides();
      logic [bidx_pkg::INDEX_W-1:0] run_a;
      logic [bidx_pkg::INDEX_W-1:0] run_b;
      logic [bidx_pkg::INDEX_W-1:0] run_out;
      int unsigned sa;
      int unsigned sb;
      run_a = 1;
      run_b = 1;
      run_out = 1;
      incompatible = 0;
      for (int k = 0; k < bidx_pkg::RANK; k++) begin
         sa = axis_size(shape_a, k);
         sb = axis_size(shape_b, k);
         if (sa != sb && sa != 1 && sb != 1)
            incompatible = 1;
         dim[k] = (sa > sb) ? sa : sb;
         pitch_a[k] = (sa == 1) ? '0 : run_a;
         pitch_b[k] = (sb == 1) ? '0 : run_b;
         pitch_out[k] = run_out;
         run_a = run_a * sa;
         run_b = run_b * sb;
         run_out = run_out * dim[k];
         position[k] = 0;
      end
   endfunction

   function void write_reg(logic [bidx_pkg::CSR_INDEX_W-1:0] index,
                           logic [bidx_pkg::SHAPE_W-1:0] data);
      if (index == bidx_pkg::CSR_SHAPE_A) begin
         shape_a = data;
         derive_strides();
      end else if (index == bidx_pkg::CSR_SHAPE_B) begin
         shape_b = data;
         derive_strides();
      end
   endfunction

   function int unsigned walk_length();
      int unsigned total;
      total = 1;
      for (int k = 0; k < bidx_pkg::RANK; k++)
         total = total * dim[k];
      return total;
   endfunction

   function int unsigned pending();
      return expected_q.size();
   endfunction

   function void note_request(logic restart);
      bidx_pkg::bidx_res_type want;
      bit at_end;
      bit carry;
      want = '0;
      if (incompatible) begin
         want.last = 1'b1;
         want.shape_error = 1'b1;
         expected_q.push_back(want);
         return;
      end
      if (restart) begin
         for (int k = 0; k < bidx_pkg::RANK; k++)
            position[k] = 0;
      end
      at_end = 1;
      for (int k = 0; k < bidx_pkg::RANK; k++) begin
         if (position[k] + 1 != dim[k])
            at_end = 0;
         want.index_a = want.index_a + 32'(position[k]) * pitch_a[k];
         want.index_b = want.index_b + 32'(position[k]) * pitch_b[k];
         want.index_out = want.index_out + 32'(position[k]) * pitch_out[k];
      end
      want.last = at_end;
      expected_q.push_back(want);
      carry = 1;
      for (int k = 0; k < bidx_pkg::RANK; k++) begin
         if (carry) begin
            if (position[k] + 1 < dim[k]) begin
               position[k] = position[k] + 1;
               carry = 0;
            end else begin
               position[k] = 0;
            end
         end
      end
   endfunction

   function void compare_field(string field, logic [bidx_pkg::INDEX_W-1:0] want,
                               logic [bidx_pkg::INDEX_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatches++;
      end
   endfunction

   function void check_result(bidx_pkg::bidx_res_type got);
      bidx_pkg::bidx_res_type want;
      if (expected_q.size() == 0) begin
         $error("result beat with no request outstanding (index_out %0d)", got.index_out);
         mismatches++;
         return;
      end
      want = expected_q.pop_front();
      beats_checked++;
      if (want.shape_error)
         error_beats++;
      else if (want.last)
         walks_done++;
      compare_field("index_a", want.index_a, got.index_a);
      compare_field("index_b", want.index_b, got.index_b);
      compare_field("index_out", want.index_out, got.index_out);
      compare_field("last", bidx_pkg::INDEX_W'(want.last), bidx_pkg::INDEX_W'(got.last));
      compare_field("shape_error", bidx_pkg::INDEX_W'(want.shape_error),
                    bidx_pkg::INDEX_W'(got.shape_error));
   endfunction
endclass

module broadcast_index_generator_tb;

   localparam logic [bidx_pkg::CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [bidx_pkg::CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;
   localparam int unsigned RANDOM_BEATS = 1600;
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_restart = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [bidx_pkg::INDEX_W-1:0] rsp_index_a;
   logic [bidx_pkg::INDEX_W-1:0] rsp_index_b;
   logic [bidx_pkg::INDEX_W-1:0] rsp_index_out;
   logic rsp_last;
   logic rsp_shape_error;
   logic csr_write = 1'b0;
   logic [bidx_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [bidx_pkg::SHAPE_W-1:0] csr_data = '0;

   int unsigned sender_idle_pct = 14;
   int unsigned recv_idle_pct = 48;
   int unsigned cycle_count = 0;

   index_scoreboard board = new();

   broadcast_index_generator dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_index_a(rsp_index_a),
      .rsp_index_b(rsp_index_b),
      .rsp_index_out(rsp_index_out),
      .rsp_last(rsp_last),
      .rsp_shape_error(rsp_shape_error),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result({rsp_index_a, rsp_index_b, rsp_index_out, rsp_last,
                             rsp_shape_error});
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("broadcast_index_generator test failed");
      $finish;
   end

   task automatic send_item(input logic restart);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      do
         @(posedge clock);
      while (req_stall);
      board.note_request(restart);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [bidx_pkg::CSR_INDEX_W-1:0] index,
                            input logic [bidx_pkg::SHAPE_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      board.write_reg(index, data);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic void pick_shapes(output logic [bidx_pkg::SHAPE_W-1:0] sa,
                                       output logic [bidx_pkg::SHAPE_W-1:0] sb);
      int unsigned style;
      int unsigned common;
      int unsigned pairing;
      int unsigned long_axis;
      int unsigned va;
      int unsigned vb;
      style = $urandom_range(15);
      long_axis = $urandom_range(bidx_pkg::RANK - 1);
      sa = {$urandom, $urandom};
      sb = {$urandom, $urandom};
      for (int k = 0; k < bidx_pkg::RANK; k++) begin
         common = ($urandom_range(4) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
         pairing = $urandom_range(3);
         va = (pairing == 2 || pairing == 3) ? 1 : common;
         vb = (pairing == 1 || pairing == 3) ? 1 : common;
         if (style == 0) begin
            va = 1;
            vb = 1;
            if (k == long_axis) begin
               va = $urandom_range(200, 255);
               vb = $urandom_range(1) ? va : 1;
            end
         end
         if (va == 1 && $urandom_range(3) == 0)
            va = 0;
         if (vb == 1 && $urandom_range(3) == 0)
            vb = 0;
         sa[8*k +: 8] = 8'(va);
         sb[8*k +: 8] = 8'(vb);
      end
      if (style == 1 || style == 2) begin
         va = $urandom_range(2, 255);
         vb = $urandom_range(2, 254);
         if (vb >= va)
            vb++;
         sa[8*long_axis +: 8] = 8'(va);
         sb[8*long_axis +: 8] = 8'(vb);
      end
   endfunction

   initial begin
      int unsigned random_beats;
      int unsigned settings;
      int unsigned n;
      int unsigned walk;
      int unsigned restart_pct;
      int unsigned pick;
      logic [bidx_pkg::SHAPE_W-1:0] next_a;
      logic [bidx_pkg::SHAPE_W-1:0] next_b;
      random_beats = 0;
      settings = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With the reset shapes every element is a one-element walk.
      send_item(1'b0);
      send_item(1'b1);
      send_item(1'b0);
      drain();

      // Sizes 3,1,1,2 against 1,1,2,1 with zero bytes and junk above the used axes.
      write_csr(bidx_pkg::CSR_SHAPE_A, 64'hA5A5_A5A5_0200_0103);
      write_csr(bidx_pkg::CSR_SHAPE_B, 64'h5A5A_5A5A_0102_0001);
      repeat (13) send_item(1'b0);
      send_item(1'b1);
      drain();

      // Largest sizes on every axis against an all-zero shape.
      write_csr(bidx_pkg::CSR_SHAPE_A, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(bidx_pkg::CSR_SHAPE_B, 64'h0000_0000_0000_0000);
      send_item(1'b0);
      send_item(1'b0);
      drain();

      // Sizes 3 and 5 on the same axis cannot be broadcast.
      write_csr(bidx_pkg::CSR_SHAPE_A, 64'h0000_0000_0000_0302);
      write_csr(bidx_pkg::CSR_SHAPE_B, 64'h0000_0000_0000_0502);
      send_item(1'b1);
      send_item(1'b0);
      drain();
      write_csr(CSR_SPARE_2, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_SPARE_3, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(1'b0);
      drain();
      settings = 4;

      while (random_beats < RANDOM_BEATS) begin
         if (random_beats < RANDOM_BEATS / 3) begin
            sender_idle_pct = 14;
            recv_idle_pct = 48;
         end else if (random_beats < 2 * RANDOM_BEATS / 3) begin
            sender_idle_pct = 48;
            recv_idle_pct = 14;
         end else begin
            sender_idle_pct = 0;
            recv_idle_pct = 0;
         end
         pick_shapes(next_a, next_b);
         pick = $urandom_range(7);
         if (pick == 0)
            write_csr($urandom_range(1) ? CSR_SPARE_3 : CSR_SPARE_2, {$urandom, $urandom});
         if (pick != 1)
            write_csr(bidx_pkg::CSR_SHAPE_A, next_a);
         if (pick != 2)
            write_csr(bidx_pkg::CSR_SHAPE_B, next_b);
         walk = board.walk_length();
         if (board.incompatible)
            n = $urandom_range(3, 8);
         else if (walk > 300)
            n = $urandom_range(40, 90);
         else
            n = walk + $urandom_range(0, walk / 2 + 2);
         case ($urandom_range(3))
            0: restart_pct = 0;
            3: restart_pct = 30;
            default: restart_pct = 3;
         endcase
         repeat (n) begin
            send_item($urandom_range(99) < restart_pct);
            random_beats++;
         end
         drain();
         settings++;
      end

      if (board.pending() != 0)
         $error("%0d expected result beats never arrived", board.pending());
      $display("Checked %0d result beats across %0d shape settings: %0d complete walks,",
               board.beats_checked, settings, board.walks_done);
      $display("%0d beats on incompatible shapes, idle mixes swept, %0d field failures.",
               board.error_beats, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("broadcast_index_generator test passed");
      else
         $display("broadcast_index_generator test failed");
      $finish;
   end
endmodule
